// ===== design/qrm_pkg.sv =====
// Shared types, widths and helpers for the quaternion to rotation matrix block.
package qrm_pkg;

  localparam int COMP_BITS     = 16;
  localparam int OUT_BITS      = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int N_ENT         = 9;
  localparam int PROD_BITS     = 2 * COMP_BITS;
  localparam int DIV_BITS      = 2 * COMP_BITS + 2;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] comp_w;
    logic signed [COMP_BITS-1:0] comp_x;
    logic signed [COMP_BITS-1:0] comp_y;
    logic signed [COMP_BITS-1:0] comp_z;
  } qrm_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] m00;
    logic signed [OUT_BITS-1:0] m01;
    logic signed [OUT_BITS-1:0] m02;
    logic signed [OUT_BITS-1:0] m10;
    logic signed [OUT_BITS-1:0] m11;
    logic signed [OUT_BITS-1:0] m12;
    logic signed [OUT_BITS-1:0] m20;
    logic signed [OUT_BITS-1:0] m21;
    logic signed [OUT_BITS-1:0] m22;
    logic                       zero_error;
  } qrm_out_t;

  typedef struct packed {
    logic              zero;
    logic [N_ENT-1:0]  neg;
  } qrm_side_t;

  typedef struct packed {
    logic                 neg;
    logic [PROD_BITS:0]   mag;
  } qrm_term_t;

  function automatic qrm_term_t qrm_combine(logic sa, logic [PROD_BITS-1:0] ma,
                                            logic sb, logic [PROD_BITS-1:0] mb);
    qrm_term_t t;
    if (sa == sb) begin
      t.neg = sa;
      t.mag = {1'b0, ma} + {1'b0, mb};
    end else if (ma >= mb) begin
      t.neg = sa;
      t.mag = {1'b0, ma} - {1'b0, mb};
    end else begin
      t.neg = sb;
      t.mag = {1'b0, mb} - {1'b0, ma};
    end
    return t;
  endfunction

endpackage

// ===== design/quaternion_to_rotation_matrix.sv =====
// Quaternion to normalized 3x3 rotation matrix, fully pipelined.
//
// Input: one quaternion word on data_i is taken at each rising edge where
// start is high and busy is low. busy stays low, so a word may be given in
// every cycle and the block sustains one word per cycle.
// Output: each result word is on result_o for exactly one cycle while
// strobe_o is high; it must be taken then, the receiver cannot stall.
// Results come out in the order the words went in.
// Stages from accept to strobe: magnitude, products, sums, FRAC_BITS + 2
// divider stages, rounding and output. The divider stages, one quotient bit
// each, set the depth.
// Entries are Q1.FRAC_BITS in 16-bit fields; a zero quaternion gives all
// entries 0 and zero_error set.
// Reset clears every valid bit; no result word follows reset until a new
// word is accepted.
module quaternion_to_rotation_matrix #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  qrm_pkg::qrm_in_t  data_i,
  output logic              strobe_o,
  output qrm_pkg::qrm_out_t result_o
);
  import qrm_pkg::*;

  localparam int C  = COMP_BITS;
  localparam int PW = PROD_BITS;
  localparam int W  = DIV_BITS;
  localparam int QW = FRAC_BITS + 2;
  localparam int VW = (FRAC_BITS + 3 > OUT_BITS) ? FRAC_BITS + 3 : OUT_BITS;

  logic acc;
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // stage 1: sign and magnitude
  logic         v1_q;
  logic [C-1:0] mg_q [4];
  logic [C-1:0] mg_d [4];
  logic [3:0]   sg_q, sg_d;
  logic [C-1:0] raw [4];

  assign raw[0] = data_i.comp_w;
  assign raw[1] = data_i.comp_x;
  assign raw[2] = data_i.comp_y;
  assign raw[3] = data_i.comp_z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sg_d[i] = raw[i][C-1];
      mg_d[i] = sg_d[i] ? C'(-raw[i]) : raw[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    mg_q <= mg_d;
    sg_q <= sg_d;
  end

  // stage 2: squares and cross products (xy, xz, yz, wx, wy, wz)
  logic          v2_q;
  logic          zero2_q;
  logic [PW-1:0] sq_q [4];
  logic [PW-1:0] sq_d [4];
  logic [PW-1:0] pr_q [6];
  logic [PW-1:0] pr_d [6];
  logic [5:0]    ps_q, ps_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_d[i] = PW'(mg_q[i]) * PW'(mg_q[i]);
    end
    pr_d[0] = PW'(mg_q[1]) * PW'(mg_q[2]);
    pr_d[1] = PW'(mg_q[1]) * PW'(mg_q[3]);
    pr_d[2] = PW'(mg_q[2]) * PW'(mg_q[3]);
    pr_d[3] = PW'(mg_q[0]) * PW'(mg_q[1]);
    pr_d[4] = PW'(mg_q[0]) * PW'(mg_q[2]);
    pr_d[5] = PW'(mg_q[0]) * PW'(mg_q[3]);
    ps_d[0] = sg_q[1] ^ sg_q[2];
    ps_d[1] = sg_q[1] ^ sg_q[3];
    ps_d[2] = sg_q[2] ^ sg_q[3];
    ps_d[3] = sg_q[0] ^ sg_q[1];
    ps_d[4] = sg_q[0] ^ sg_q[2];
    ps_d[5] = sg_q[0] ^ sg_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q    <= sq_d;
    pr_q    <= pr_d;
    ps_q    <= ps_d;
    zero2_q <= ((mg_q[0] | mg_q[1] | mg_q[2] | mg_q[3]) == '0);
  end

  // stage 3: square magnitude and dividends
  logic         v3_q;
  logic [W-1:0] s_q, s_d;
  logic [W-1:0] a_q [N_ENT];
  logic [W-1:0] a_d [N_ENT];
  qrm_side_t    side3_q, side3_d;
  qrm_term_t    tm [N_ENT];

  always_comb begin
    tm[0] = '{neg: 1'b0, mag: {1'b0, sq_q[2]} + {1'b0, sq_q[3]}};
    tm[1] = qrm_combine(ps_q[0], pr_q[0], ~ps_q[5], pr_q[5]);
    tm[2] = qrm_combine(ps_q[1], pr_q[1],  ps_q[4], pr_q[4]);
    tm[3] = qrm_combine(ps_q[0], pr_q[0],  ps_q[5], pr_q[5]);
    tm[4] = '{neg: 1'b0, mag: {1'b0, sq_q[1]} + {1'b0, sq_q[3]}};
    tm[5] = qrm_combine(ps_q[2], pr_q[2], ~ps_q[3], pr_q[3]);
    tm[6] = qrm_combine(ps_q[1], pr_q[1], ~ps_q[4], pr_q[4]);
    tm[7] = qrm_combine(ps_q[2], pr_q[2],  ps_q[3], pr_q[3]);
    tm[8] = '{neg: 1'b0, mag: {1'b0, sq_q[1]} + {1'b0, sq_q[2]}};
    s_d = W'(sq_q[0]) + W'(sq_q[1]) + W'(sq_q[2]) + W'(sq_q[3]);
    side3_d.zero = zero2_q;
    for (int l = 0; l < N_ENT; l++) begin
      a_d[l]           = {tm[l].mag, 1'b0};
      side3_d.neg[l]   = tm[l].neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    a_q     <= a_d;
    side3_q <= side3_d;
  end

  // divider
  logic          dv_vld;
  logic [QW-1:0] dv_quo [N_ENT];
  qrm_side_t     dv_side;

  qrm_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .den_i   (s_q),
    .num_i   (a_q),
    .side_i  (side3_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // output stage: sign, diagonal offset, zero case
  logic              out_vld_q;
  qrm_out_t          out_q, out_d;
  logic [OUT_BITS-1:0] ent [N_ENT];

  always_comb begin
    logic [VW-1:0] q;
    logic [VW-1:0] v;
    for (int l = 0; l < N_ENT; l++) begin
      q = VW'(dv_quo[l]);
      if (l == 0 || l == 4 || l == 8) begin
        v = (VW'(1) << FRAC_BITS) - q;
      end else begin
        v = dv_side.neg[l] ? VW'(-q) : q;
      end
      ent[l] = dv_side.zero ? '0 : v[OUT_BITS-1:0];
    end
    out_d.m00        = ent[0];
    out_d.m01        = ent[1];
    out_d.m02        = ent[2];
    out_d.m10        = ent[3];
    out_d.m11        = ent[4];
    out_d.m12        = ent[5];
    out_d.m20        = ent[6];
    out_d.m21        = ent[7];
    out_d.m22        = ent[8];
    out_d.zero_error = dv_side.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign strobe_o = out_vld_q;
  assign result_o = out_q;

endmodule

// ===== design/qrm_divider.sv =====
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient bit per stage.
module qrm_divider #(
  parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [qrm_pkg::DIV_BITS-1:0]         den_i,
  input  logic [qrm_pkg::DIV_BITS-1:0]         num_i [qrm_pkg::N_ENT],
  input  qrm_pkg::qrm_side_t                   side_i,
  output logic                                 valid_o,
  output logic [FRAC_BITS+1:0]                 quo_o [qrm_pkg::N_ENT],
  output qrm_pkg::qrm_side_t                   side_o
);
  import qrm_pkg::*;

  localparam int NSTEP = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 2;
  localparam int W     = DIV_BITS;

  logic [NSTEP-1:0] vld_q;
  logic [W-1:0]     den_q [NSTEP];
  logic [W-1:0]     rem_q [NSTEP][N_ENT];
  logic [QW-1:0]    quo_q [NSTEP][N_ENT];
  qrm_side_t        side_q [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic          vin;
    logic [W-1:0]  din;
    logic [W-1:0]  rin [N_ENT];
    logic [QW-1:0] qin [N_ENT];
    qrm_side_t     sin;
    logic [W-1:0]  rem_d [N_ENT];
    logic [QW-1:0] quo_d [N_ENT];

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign din = den_i;
      assign sin = side_i;
      for (genvar l = 0; l < N_ENT; l++) begin : g_l
        assign rin[l] = num_i[l];
        assign qin[l] = '0;
      end
    end else begin : g_next
      assign vin = vld_q[j-1];
      assign din = den_q[j-1];
      assign sin = side_q[j-1];
      for (genvar l = 0; l < N_ENT; l++) begin : g_l
        assign rin[l] = rem_q[j-1][l];
        assign qin[l] = quo_q[j-1][l];
      end
    end

    always_comb begin
      logic [W-1:0]  rs;
      logic [QW-1:0] qs;
      logic          ge;
      for (int l = 0; l < N_ENT; l++) begin
        rs = (j < 2) ? rin[l] : {rin[l][W-2:0], 1'b0};
        qs = (j < 2) ? qin[l] : {qin[l][QW-2:0], 1'b0};
        ge = (rs >= din);
        rem_d[l] = ge ? rs - din : rs;
        quo_d[l] = (j < 2) ? qs + QW'(ge) : (qs | QW'(ge));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[j]  <= din;
      side_q[j] <= sin;
      rem_q[j]  <= rem_d;
      quo_q[j]  <= quo_d;
    end
  end

  logic          rnd_vld_q;
  logic [QW-1:0] rnd_quo_q [N_ENT];
  logic [QW-1:0] rnd_quo_d [N_ENT];
  qrm_side_t     rnd_side_q;

  always_comb begin
    for (int l = 0; l < N_ENT; l++) begin
      rnd_quo_d[l] = quo_q[NSTEP-1][l]
                   + QW'({rem_q[NSTEP-1][l][W-2:0], 1'b0} >= den_q[NSTEP-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_vld_q <= 1'b0;
    end else begin
      rnd_vld_q <= vld_q[NSTEP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_quo_q  <= rnd_quo_d;
    rnd_side_q <= side_q[NSTEP-1];
  end

  assign valid_o = rnd_vld_q;
  assign quo_o   = rnd_quo_q;
  assign side_o  = rnd_side_q;

endmodule
